// File: design/sas_pkg.sv
// sas_pkg: request codes and fixed field widths for the sprite animation sequencer
// no dependencies; imported by sprite_animation_sequencer, sas_checker and the testbench
package sas_pkg;

   // widths of the transaction fields on the ports
   localparam int unsigned TYPE_W  = 3;
   localparam int unsigned FRAME_W = 16;
   localparam int unsigned SPEED_W = 16;
   localparam int unsigned LIFE_W  = 32;

   // request codes; the remaining codes leave the state untouched
   typedef enum logic [TYPE_W-1:0] {
      REQ_TICK      = 3'd0,
      REQ_START     = 3'd1,
      REQ_STOP      = 3'd2,
      REQ_SET_FRAME = 3'd3,
      REQ_SET_LIFE  = 3'd4
   } req_code_type;

endpackage

// File: design/sprite_animation_sequencer.sv
// sprite_animation_sequencer: frame position, play state and life counter of one sprite
// depends on sas_pkg
//
// Takes one request transaction per clock while req_stall is low and answers each
// with exactly one response transaction, in order. A request is captured in an input
// register; one state-update stage then applies it (an add or subtract of the speed
// and a few compares) and loads the response register, which holds the response
// until it is taken. Throughput is one request per cycle while the response side
// does not stall, set by that single update stage, which always sees the state left
// by the request before it. Back-pressure on the response side holds the response
// register and then the input register; the input register keeps accepting while a
// finished response waits, as long as it is free.
// Position is fixed point with SPEED_FRAC_BITS fraction bits; frame_index reads it
// truncated toward zero.
module sprite_animation_sequencer #(
   parameter int unsigned FRAME_BITS      = 16,
   parameter int unsigned SPEED_FRAC_BITS = 8,
   parameter int unsigned LIFE_BITS       = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [sas_pkg::TYPE_W-1:0]   req_type,
   input  logic [sas_pkg::FRAME_W-1:0]  req_first_frame,
   input  logic [sas_pkg::FRAME_W-1:0]  req_last_frame,
   input  logic [sas_pkg::SPEED_W-1:0]  req_speed,
   input  logic                         req_looping,
   input  logic                         req_keep_frame,
   input  logic [sas_pkg::FRAME_W-1:0]  req_frame_value,
   input  logic [sas_pkg::LIFE_W-1:0]   req_life_value,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [sas_pkg::FRAME_W-1:0]  rsp_frame_index,
   output logic                         rsp_is_playing,
   output logic                         rsp_delete_object,
   output logic [sas_pkg::LIFE_W-1:0]   rsp_life_left
);
   import sas_pkg::*;

   localparam int unsigned FB    = FRAME_BITS;
   localparam int unsigned FRAC  = SPEED_FRAC_BITS;
   localparam int unsigned LB    = LIFE_BITS;
   // integer part plus fraction, or the speed if wider, plus carry and sign
   localparam int unsigned POS_W = ((FB + FRAC) > SPEED_W) ? (FB + FRAC + 2) : (SPEED_W + 2);
   localparam logic signed [POS_W-1:0] NEG_UNIT = -($signed(POS_W'(1)) <<< FRAC);

   // input register
   logic                 s1_valid_ff, s1_valid_in;
   logic [TYPE_W-1:0]    s1_type_ff;
   logic [FB-1:0]        s1_first_ff;
   logic [FB-1:0]        s1_last_ff;
   logic [SPEED_W-1:0]   s1_speed_ff;
   logic                 s1_looping_ff;
   logic                 s1_keep_ff;
   logic [FB-1:0]        s1_frame_ff;
   logic [LB-1:0]        s1_life_ff;

   // sprite state
   logic signed [POS_W-1:0] pos_ff, pos_in;
   logic                    running_ff, running_in;
   logic [FB-1:0]           first_ff, first_in;
   logic [FB-1:0]           last_ff, last_in;
   logic [SPEED_W-1:0]      step_ff, step_in;
   logic                    loop_ff, loop_in;
   logic                    life_en_ff, life_en_in;
   logic [LB-1:0]           life_ff, life_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [FB-1:0]        rsp_frame_ff;
   logic                 rsp_playing_ff;
   logic                 rsp_delete_ff;
   logic [LB-1:0]        rsp_life_ff;

   logic                 out_free;
   logic                 s1_fire;
   logic                 req_accept;
   logic                 del_in;

   logic signed [POS_W-1:0] step_ext;
   logic signed [POS_W-1:0] pos_fwd;
   logic signed [POS_W-1:0] pos_bwd;
   logic signed [POS_W-1:0] first_pos;
   logic signed [POS_W-1:0] last_pos;
   logic signed [POS_W-1:0] past_last_pos;
   logic signed [POS_W-1:0] new_first_pos;
   logic signed [POS_W-1:0] new_last_pos;
   logic signed [POS_W-1:0] set_pos;
   logic                    outside;
   logic [POS_W-1:0]        pos_mag;
   logic [POS_W-1:0]        mag_int;
   logic [POS_W-1:0]        trunc_val;
   logic [LB-1:0]           life_dec;

   // handshake
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_fire     = s1_valid_ff && out_free;
   assign req_stall   = s1_valid_ff && !out_free;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_type_ff    <= req_type;
         s1_first_ff   <= req_first_frame[FB-1:0];
         s1_last_ff    <= req_last_frame[FB-1:0];
         s1_speed_ff   <= req_speed;
         s1_looping_ff <= req_looping;
         s1_keep_ff    <= req_keep_frame;
         s1_frame_ff   <= req_frame_value[FB-1:0];
         s1_life_ff    <= req_life_value[LB-1:0];
      end
   end

   // fixed-point forms of frames and speed
   assign step_ext      = $signed({{(POS_W-SPEED_W){1'b0}}, step_ff});
   assign pos_fwd       = pos_ff + step_ext;
   assign pos_bwd       = pos_ff - step_ext;
   assign first_pos     = $signed({{(POS_W-FB){1'b0}}, first_ff}) <<< FRAC;
   assign last_pos      = $signed({{(POS_W-FB){1'b0}}, last_ff}) <<< FRAC;
   assign past_last_pos = $signed({{(POS_W-FB-1){1'b0}}, {1'b0, last_ff} + (FB+1)'(1)})
                          <<< FRAC;
   assign new_first_pos = $signed({{(POS_W-FB){1'b0}}, s1_first_ff}) <<< FRAC;
   assign new_last_pos  = $signed({{(POS_W-FB){1'b0}}, s1_last_ff}) <<< FRAC;
   assign set_pos       = $signed({{(POS_W-FB){1'b0}}, s1_frame_ff}) <<< FRAC;
   assign outside       = (pos_ff < new_first_pos) || (pos_ff > new_last_pos);
   assign life_dec      = (life_ff != '0) ? (life_ff - LB'(1)) : life_ff;

   // apply one request to the state
   always_comb begin
      pos_in     = pos_ff;
      running_in = running_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      step_in    = step_ff;
      loop_in    = loop_ff;
      life_en_in = life_en_ff;
      life_in    = life_ff;
      del_in     = 1'b0;
      if (s1_fire) begin
         unique case (req_code_type'(s1_type_ff))
            REQ_TICK: begin
               if (running_ff) begin
                  if (first_ff < last_ff) begin
                     // forward: wrap once the integer frame passes last
                     if (pos_fwd >= past_last_pos) begin
                        pos_in     = first_pos;
                        running_in = loop_ff;
                     end else begin
                        pos_in = pos_fwd;
                     end
                  end else begin
                     // backward: wrap once the integer frame drops under last
                     if ((last_ff == '0) ? (pos_bwd <= NEG_UNIT) : (pos_bwd < last_pos)) begin
                        pos_in     = first_pos;
                        running_in = loop_ff;
                     end else begin
                        pos_in = pos_bwd;
                     end
                  end
               end
               if (life_en_ff) begin
                  life_in = life_dec;
                  del_in  = (life_dec == '0);
               end
            end
            REQ_START: begin
               if ((!s1_looping_ff && !running_ff) || (s1_looping_ff && outside)) begin
                  pos_in = new_first_pos;
               end
               first_in   = s1_first_ff;
               last_in    = s1_last_ff;
               step_in    = s1_speed_ff;
               loop_in    = s1_looping_ff;
               running_in = 1'b1;
            end
            REQ_STOP: begin
               running_in = 1'b0;
               if (!s1_keep_ff) begin
                  pos_in = '0;
               end
            end
            REQ_SET_FRAME: begin
               pos_in = set_pos;
            end
            REQ_SET_LIFE: begin
               life_en_in = 1'b1;
               life_in    = s1_life_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // truncate the new position toward zero
   always_comb begin
      pos_mag   = pos_in[POS_W-1] ? (POS_W)'(-pos_in) : (POS_W)'(pos_in);
      mag_int   = pos_mag >> FRAC;
      trunc_val = pos_in[POS_W-1] ? (POS_W)'(-mag_int) : mag_int;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         running_ff <= 1'b0;
         first_ff   <= '0;
         last_ff    <= '0;
         step_ff    <= '0;
         loop_ff    <= 1'b0;
         life_en_ff <= 1'b0;
         life_ff    <= '0;
      end else begin
         pos_ff     <= pos_in;
         running_ff <= running_in;
         first_ff   <= first_in;
         last_ff    <= last_in;
         step_ff    <= step_in;
         loop_ff    <= loop_in;
         life_en_ff <= life_en_in;
         life_ff    <= life_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_fire) begin
         rsp_frame_ff   <= trunc_val[FB-1:0];
         rsp_playing_ff <= running_in;
         rsp_delete_ff  <= del_in;
         rsp_life_ff    <= life_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_index   = FRAME_W'(rsp_frame_ff);
   assign rsp_is_playing    = rsp_playing_ff;
   assign rsp_delete_object = rsp_delete_ff;
   assign rsp_life_left     = LIFE_W'(rsp_life_ff);

endmodule

// File: design/sas_checker.sv
// sas_checker: port-level assertions for the sprite animation sequencer
// depends on sas_pkg; bound to sprite_animation_sequencer at the end of this file
module sas_checker #(
   parameter int unsigned FRAME_BITS = 16,
   parameter int unsigned LIFE_BITS  = 32
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [sas_pkg::FRAME_W-1:0]  rsp_frame_index,
   input logic                         rsp_is_playing,
   input logic                         rsp_delete_object,
   input logic [sas_pkg::LIFE_W-1:0]   rsp_life_left
);
   import sas_pkg::*;

   // no response transaction right after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a deletion flag only comes with an exhausted life counter
   a_delete_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_delete_object) |-> (rsp_life_left == '0))
      else $error("delete flagged with life left");

   // frame index stays within the configured frame width
   a_frame_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_frame_index >> FRAME_BITS) == '0))
      else $error("frame index out of range");

   // life count stays within the configured counter width
   a_life_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_life_left >> LIFE_BITS) == '0))
      else $error("life count out of range");

   // a stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_frame_index)
         && $stable(rsp_is_playing) && $stable(rsp_delete_object)
         && $stable(rsp_life_left)))
      else $error("stalled response changed");

endmodule

bind sprite_animation_sequencer sas_checker #(
   .FRAME_BITS (FRAME_BITS),
   .LIFE_BITS  (LIFE_BITS)
) u_sas_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_frame_index   (rsp_frame_index),
   .rsp_is_playing    (rsp_is_playing),
   .rsp_delete_object (rsp_delete_object),
   .rsp_life_left     (rsp_life_left)
);

// File: test/sprite_animation_sequencer_tb.sv
// sprite_animation_sequencer_tb: self-checking bench for the sprite frame sequencer
// depends on sas_pkg and sprite_animation_sequencer; a local model predicts each response
module sprite_animation_sequencer_tb;
   import sas_pkg::*;

   localparam int unsigned FRAC_BITS = 8;
   localparam int unsigned N_RANDOM  = 800;
   localparam int unsigned SHOW_MAX  = 10;

   // request codes with no action in the block
   localparam logic [TYPE_W-1:0] REQ_SPARE_LO  = 3'd5;
   localparam logic [TYPE_W-1:0] REQ_SPARE_MID = 3'd6;
   localparam logic [TYPE_W-1:0] REQ_SPARE_HI  = 3'd7;

   typedef struct {
      logic [TYPE_W-1:0]  op;
      logic [FRAME_W-1:0] first;
      logic [FRAME_W-1:0] last;
      logic [SPEED_W-1:0] speed;
      logic               loop;
      logic               keep;
      logic [FRAME_W-1:0] frame;
      logic [LIFE_W-1:0]  life;
   } anim_req_type;

   typedef struct {
      logic [FRAME_W-1:0] frame;
      logic               playing;
      logic               del;
      logic [LIFE_W-1:0]  life;
   } anim_rsp_type;

   typedef struct {
      anim_req_type rq;
      bit           typed;
      anim_rsp_type want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [TYPE_W-1:0] req_type;
   logic [FRAME_W-1:0] req_first_frame;
   logic [FRAME_W-1:0] req_last_frame;
   logic [SPEED_W-1:0] req_speed;
   logic req_looping;
   logic req_keep_frame;
   logic [FRAME_W-1:0] req_frame_value;
   logic [LIFE_W-1:0] req_life_value;
   logic rsp_valid;
   logic rsp_stall;
   logic [FRAME_W-1:0] rsp_frame_index;
   logic rsp_is_playing;
   logic rsp_delete_object;
   logic [LIFE_W-1:0] rsp_life_left;

   sprite_animation_sequencer #(
      .FRAME_BITS      (FRAME_W),
      .SPEED_FRAC_BITS (FRAC_BITS),
      .LIFE_BITS       (LIFE_W)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_first_frame   (req_first_frame),
      .req_last_frame    (req_last_frame),
      .req_speed         (req_speed),
      .req_looping       (req_looping),
      .req_keep_frame    (req_keep_frame),
      .req_frame_value   (req_frame_value),
      .req_life_value    (req_life_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_is_playing    (rsp_is_playing),
      .rsp_delete_object (rsp_delete_object),
      .rsp_life_left     (rsp_life_left)
   );

   // predicted sprite state
   logic signed [63:0] pos_q;
   logic               play_q;
   logic [FRAME_W-1:0] first_q;
   logic [FRAME_W-1:0] last_q;
   logic [SPEED_W-1:0] speed_q;
   logic               loop_q;
   logic               life_on_q;
   logic [LIFE_W-1:0]  life_q;

   anim_rsp_type pending_rsp[$];
   stim_row_type dir_rows[$];

   int unsigned n_sent;
   int unsigned n_checked;
   int unsigned n_wraps;
   int unsigned n_deletes;
   int unsigned n_mismatch;
   int unsigned n_orphan;
   bit          no_idle;
   bit          drain_hold;
   bit          stim_done;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #400000;
      $display("timeout: %0d requests sent, %0d responses checked", n_sent, n_checked);
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic signed [63:0] frame_to_pos(input logic [FRAME_W-1:0] f);
      logic signed [63:0] p;
      p = $signed(64'(f));
      return p <<< FRAC_BITS;
   endfunction

   // truncation toward zero
   function automatic logic signed [63:0] pos_to_frame(input logic signed [63:0] p);
      if (p < 0) begin
         return -((-p) >>> FRAC_BITS);
      end
      return p >>> FRAC_BITS;
   endfunction

   function automatic void wrap_to_start();
      pos_q = frame_to_pos(first_q);
      if (!loop_q) begin
         play_q = 1'b0;
      end
      n_wraps++;
   endfunction

   // apply one request to the predicted state, return its response
   function automatic anim_rsp_type advance_sprite(input anim_req_type rq);
      anim_rsp_type       r;
      logic signed [63:0] frm;
      logic signed [63:0] end_frm;
      logic               outside;
      r.del = 1'b0;
      end_frm = $signed(64'(last_q));
      case (rq.op)
         REQ_TICK: begin
            if (play_q) begin
               if (first_q < last_q) begin
                  pos_q = pos_q + $signed(64'(speed_q));
                  if (pos_to_frame(pos_q) > end_frm) begin
                     wrap_to_start();
                  end
               end else begin
                  pos_q = pos_q - $signed(64'(speed_q));
                  if (pos_to_frame(pos_q) < end_frm) begin
                     wrap_to_start();
                  end
               end
            end
            if (life_on_q) begin
               if (life_q != '0) begin
                  life_q = life_q - 1'b1;
               end
               if (life_q == '0) begin
                  r.del = 1'b1;
                  n_deletes++;
               end
            end
         end
         REQ_START: begin
            outside = (pos_q < frame_to_pos(rq.first)) || (pos_q > frame_to_pos(rq.last));
            if ((!rq.loop && !play_q) || (rq.loop && outside)) begin
               pos_q = frame_to_pos(rq.first);
            end
            first_q = rq.first;
            last_q  = rq.last;
            speed_q = rq.speed;
            loop_q  = rq.loop;
            play_q  = 1'b1;
         end
         REQ_STOP: begin
            play_q = 1'b0;
            if (!rq.keep) begin
               pos_q = '0;
            end
         end
         REQ_SET_FRAME: begin
            pos_q = frame_to_pos(rq.frame);
         end
         REQ_SET_LIFE: begin
            life_on_q = 1'b1;
            life_q    = rq.life;
         end
         default: begin
         end
      endcase
      frm = pos_to_frame(pos_q);
      r.frame   = frm[FRAME_W-1:0];
      r.playing = play_q;
      r.life    = life_q;
      return r;
   endfunction

   function automatic anim_req_type make_req(input logic [TYPE_W-1:0] op,
                                             input logic [FRAME_W-1:0] first,
                                             input logic [FRAME_W-1:0] last,
                                             input logic [SPEED_W-1:0] speed,
                                             input logic loop, input logic keep,
                                             input logic [FRAME_W-1:0] frame,
                                             input logic [LIFE_W-1:0] life);
      anim_req_type rq;
      rq.op    = op;
      rq.first = first;
      rq.last  = last;
      rq.speed = speed;
      rq.loop  = loop;
      rq.keep  = keep;
      rq.frame = frame;
      rq.life  = life;
      return rq;
   endfunction

   function automatic anim_rsp_type make_rsp(input logic [FRAME_W-1:0] frame,
                                             input logic playing, input logic del,
                                             input logic [LIFE_W-1:0] life);
      anim_rsp_type r;
      r.frame   = frame;
      r.playing = playing;
      r.del     = del;
      r.life    = life;
      return r;
   endfunction

   task automatic add_row(input anim_req_type rq, input bit typed, input anim_rsp_type want);
      stim_row_type row;
      row.rq    = rq;
      row.typed = typed;
      row.want  = want;
      dir_rows.insert(dir_rows.size(), row);
   endtask

   // random request, mostly well-formed playback sequences over short ranges
   function automatic anim_req_type random_req();
      anim_req_type rq;
      int unsigned  pick;
      int unsigned  base;
      int unsigned  span;
      rq = make_req(TYPE_W'($urandom), FRAME_W'($urandom), FRAME_W'($urandom),
                    SPEED_W'($urandom), 1'($urandom), 1'($urandom),
                    FRAME_W'($urandom), LIFE_W'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         rq.op = REQ_TICK;
      end else if (pick < 64) begin
         rq.op = REQ_START;
         if ($urandom_range(0, 9) != 0) begin
            span = $urandom_range(0, 24);
            base = ($urandom_range(0, 7) == 0) ? 65535 - span
                                               : $urandom_range(0, 65535 - span);
            if ($urandom_range(0, 1) != 0) begin
               rq.first = FRAME_W'(base);
               rq.last  = FRAME_W'(base + span);
            end else begin
               rq.first = FRAME_W'(base + span);
               rq.last  = FRAME_W'(base);
            end
            rq.speed = SPEED_W'($urandom_range(0, 16'h0600));
         end
      end else if (pick < 72) begin
         rq.op = REQ_STOP;
      end else if (pick < 82) begin
         rq.op = REQ_SET_FRAME;
         if ($urandom_range(0, 1) != 0) begin
            rq.frame = first_q + FRAME_W'($urandom_range(0, 24)) - FRAME_W'(4);
         end
      end else if (pick < 92) begin
         rq.op = REQ_SET_LIFE;
         if ($urandom_range(0, 7) != 0) begin
            rq.life = LIFE_W'($urandom_range(0, 40));
         end
      end else begin
         rq.op = REQ_SPARE_LO + TYPE_W'($urandom_range(0, 2));
      end
      return rq;
   endfunction

   // offer one request, wait for acceptance, record the predicted response
   task automatic send_request(input anim_req_type rq, input bit typed,
                               input anim_rsp_type want);
      int unsigned  gap;
      anim_rsp_type got;
      gap = (no_idle || drain_hold) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= rq.op;
      req_first_frame <= rq.first;
      req_last_frame  <= rq.last;
      req_speed       <= rq.speed;
      req_looping     <= rq.loop;
      req_keep_frame  <= rq.keep;
      req_frame_value <= rq.frame;
      req_life_value  <= rq.life;
      do @(posedge clock); while (req_stall);
      got = advance_sprite(rq);
      pending_rsp.insert(pending_rsp.size(), typed ? want : got);
      n_sent++;
   endtask

   // request side and end of run
   initial begin
      anim_rsp_type none;
      int unsigned  k;
      none = make_rsp('0, 1'b0, 1'b0, '0);
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_type        <= REQ_TICK;
      req_first_frame <= '0;
      req_last_frame  <= '0;
      req_speed       <= '0;
      req_looping     <= 1'b0;
      req_keep_frame  <= 1'b0;
      req_frame_value <= '0;
      req_life_value  <= '0;
      pos_q = '0; play_q = 1'b0; first_q = '0; last_q = '0;
      speed_q = '0; loop_q = 1'b0; life_on_q = 1'b0; life_q = '0;

      // directed table: reset state, spare codes, life extremes, position extremes
      add_row(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 1, make_rsp(0, 0, 0, 0));
      add_row(make_req(REQ_SPARE_HI, '1, '1, '1, 1, 1, '1, '1), 1, make_rsp(0, 0, 0, 0));
      add_row(make_req(REQ_SPARE_LO, 0, 0, 0, 0, 0, 0, 0), 1, make_rsp(0, 0, 0, 0));
      add_row(make_req(REQ_SPARE_MID, 0, 0, 0, 0, 0, 0, 0), 1, make_rsp(0, 0, 0, 0));
      add_row(make_req(REQ_SET_LIFE, 0, 0, 0, 0, 0, 0, 0), 1, make_rsp(0, 0, 0, 0));
      // life exhausted, then held at zero
      add_row(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 1, make_rsp(0, 0, 1, 0));
      add_row(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 1, make_rsp(0, 0, 1, 0));
      add_row(make_req(REQ_SET_LIFE, 0, 0, 0, 0, 0, 0, '1), 1, make_rsp(0, 0, 0, '1));
      add_row(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 1,
              make_rsp(0, 0, 0, 32'hFFFF_FFFE));
      add_row(make_req(REQ_SET_FRAME, 0, 0, 0, 0, 0, '1, 0), 1,
              make_rsp('1, 0, 0, 32'hFFFF_FFFE));
      add_row(make_req(REQ_START, 0, '1, '1, 0, 0, 0, 0), 1,
              make_rsp(0, 1, 0, 32'hFFFF_FFFE));
      add_row(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 0, none);
      // restart while running, position outside the new range
      add_row(make_req(REQ_START, 16'hFFF0, '1, 16'h0800, 1, 0, 0, 0), 0, none);
      add_row(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 0, none);
      // backward run that dips just below zero, then wraps
      add_row(make_req(REQ_START, 2, 0, 16'h0280, 1, 0, 0, 0), 0, none);
      add_row(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 0, none);
      // start keeps the position while running without looping
      add_row(make_req(REQ_START, 2, 0, 16'h0080, 0, 0, 0, 0), 0, none);
      add_row(make_req(REQ_STOP, 0, 0, 0, 0, 1, 0, 0), 0, none);
      // one-shot forward run that stops at the wrap
      add_row(make_req(REQ_START, 10, 12, 16'h0100, 0, 0, 0, 0), 0, none);
      add_row(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(make_req(REQ_STOP, 0, 0, 0, 0, 0, 0, 0), 0, none);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_request(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
      end
      // random part, with a stretch of back-to-back traffic every 200 requests
      for (k = 0; k < N_RANDOM; k++) begin
         no_idle <= ((k % 200) >= 100) && ((k % 200) < 140);
         send_request(random_req(), 0, none);
      end
      req_valid <= 1'b0;
      no_idle   <= 1'b0;
      stim_done = 1'b1;

      // drain and let the pipeline settle
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("%0d requests (%0d directed) checked as %0d responses", n_sent,
               dir_rows.size(), n_checked);
      $display("%0d frame wraps, %0d deletion flags predicted", n_wraps, n_deletes);
      if (n_mismatch == 0 && n_orphan == 0 && pending_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches, %0d unexpected, %0d missing", n_mismatch, n_orphan,
                  pending_rsp.size());
         $display("TB_ERROR");
      end
      $finish;
   end

   // response side: random stalls, compare each transaction with the oldest prediction
   initial begin
      int unsigned  hold;
      anim_rsp_type want;
      rsp_stall <= 1'b1;
      @(negedge reset);
      forever begin
         hold = no_idle ? 0 : $urandom_range(0, 6);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         while (drain_hold) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         if (pending_rsp.size() == 0) begin
            n_orphan++;
            if (n_orphan + n_mismatch <= SHOW_MAX) begin
               $display("unexpected response frame=%h playing=%b del=%b life=%h",
                        rsp_frame_index, rsp_is_playing, rsp_delete_object, rsp_life_left);
            end
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_frame_index !== want.frame || rsp_is_playing !== want.playing ||
                rsp_delete_object !== want.del || rsp_life_left !== want.life) begin
               n_mismatch++;
               if (n_orphan + n_mismatch <= SHOW_MAX) begin
                  $display("response %0d: expected frame=%h playing=%b del=%b life=%h",
                           n_checked, want.frame, want.playing, want.del, want.life);
                  $display("response %0d: actual   frame=%h playing=%b del=%b life=%h",
                           n_checked, rsp_frame_index, rsp_is_playing,
                           rsp_delete_object, rsp_life_left);
               end
            end
            n_checked++;
         end
      end
   end

   // long receiver hold-off so the block fills and stalls its request side
   initial begin
      drain_hold <= 1'b0;
      @(negedge reset);
      while (n_checked < 150 && !stim_done) @(posedge clock);
      drain_hold <= 1'b1;
      repeat (100) @(posedge clock);
      drain_hold <= 1'b0;
   end

endmodule
